// ----- design/pat_pkg.sv -----
// Shared types and constants of the planar arm tip pose block.
// Used by the channel interfaces, the sine pipeline, the top level and the checker.
`timescale 1ns / 1ps

package pat_pkg;

  // Payload types of the channels.
  typedef logic signed [15:0] angle_t;
  typedef logic signed [23:0] coord_t;
  typedef logic signed [15:0] head_t;
  typedef logic signed [15:0] dir_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LINK_LENGTH = 1'b0,
    REG_BODY_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int unsigned CFG_W       = 16;
  localparam logic [CFG_W-1:0] LINK_LENGTH_RST = 16'd2560;
  localparam logic [CFG_W-1:0] BODY_HEIGHT_RST = 16'd2560;

  // Angles are in 1/64 degree.
  localparam int unsigned QUARTER_TURN = 5760;
  localparam int unsigned HALF_TURN    = 11520;
  localparam int unsigned FULL_TURN    = 23040;
  localparam int unsigned TURN_OFFSET  = 5 * FULL_TURN;

  // pi in Q30, and its split as PI_DIV * HALF_TURN + PI_REM.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [18:0] PI_DIV = 19'd292817;
  localparam logic [12:0] PI_REM = 13'd7586;

  // Reciprocals of 45 for exact floor division on bounded values.
  localparam logic [10:0] RCP45_S = 11'd1457;      // shift 16
  localparam logic [20:0] RCP45_L = 21'd1491309;   // shift 26

  // Quarter-turn reduced angle and Q30 sine widths.
  localparam int unsigned ANG_RW = 13;
  localparam int unsigned SIN_W  = 31;
  localparam logic [SIN_W-1:0] ONE_Q30 = 31'h4000_0000;

  // Taylor terms after the first, and register stages of the sine pipeline.
  localparam int unsigned SIN_TERMS = 8;
  localparam int unsigned SIN_LAT   = 3 + 5 * SIN_TERMS + 1;

endpackage

// ----- design/pat_in_if.sv -----
// Input channel of the planar arm tip pose block: joint angles and base position.
// Depends on pat_pkg for the payload types.
`timescale 1ns / 1ps

interface pat_in_if import pat_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t joint_one_angle;
  angle_t joint_two_angle;
  angle_t joint_three_angle;
  coord_t base_x;
  coord_t base_y;

  modport source (
    output valid, joint_one_angle, joint_two_angle, joint_three_angle, base_x, base_y,
    input  ready
  );
  modport sink (
    input  valid, joint_one_angle, joint_two_angle, joint_three_angle, base_x, base_y,
    output ready
  );
endinterface

// ----- design/pat_out_if.sv -----
// Result channel of the planar arm tip pose block: tip position, heading, direction.
// Depends on pat_pkg for the payload types.
`timescale 1ns / 1ps

interface pat_out_if import pat_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t tip_x;
  coord_t tip_y;
  head_t  heading;
  dir_t   dir_x;
  dir_t   dir_y;

  modport source (
    output valid, tip_x, tip_y, heading, dir_x, dir_y,
    input  ready
  );
  modport sink (
    input  valid, tip_x, tip_y, heading, dir_x, dir_y,
    output ready
  );
endinterface

// ----- design/pat_sinq.sv -----
// Pipelined Q30 sine of a first-quadrant angle by a truncated Taylor series.
// Depends on pat_pkg; takes one angle per enabled cycle.
`timescale 1ns / 1ps

module pat_sinq import pat_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ANG_RW-1:0] ang,
  output logic [SIN_W-1:0]  sin_q
);

  // Radian conversion: x = round(ang * pi / HALF_TURN) in Q30.
  logic [30:0] ra_r, ra2_r;
  logic [17:0] w_r;
  logic [38:0] wp_r;
  logic [30:0] x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r  <= 31'(32'(ang) * 32'(PI_DIV));
      w_r   <= 18'((27'(ang) * 27'(PI_REM) + 27'(HALF_TURN / 2)) >> 8);
      ra2_r <= ra_r;
      wp_r  <= 39'(w_r) * 39'(RCP45_L);
      x_r   <= ra2_r + 31'(wp_r[38:26]);
    end
  end

  logic [30:0]        it_x    [0:SIN_TERMS];
  logic [30:0]        it_term [0:SIN_TERMS];
  logic signed [34:0] it_sum  [0:SIN_TERMS];

  assign it_x[0]    = x_r;
  assign it_term[0] = x_r;
  assign it_sum[0]  = '0;

  for (genvar n = 1; n <= SIN_TERMS; n++) begin : g_term
    localparam int unsigned DIV = (2 * n) * (2 * n + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 33) / 64'(DIV));

    logic [31:0]        t1_r;
    logic [32:0]        t2_r, u3_r;
    logic [63:0]        p_r;
    logic [30:0]        q0_r, q_r;
    logic [9:0]         rem_r;
    logic [30:0]        x1_r, x2_r, x3_r, x4_r, x5_r;
    logic signed [34:0] s1_r, s2_r, s3_r, s4_r, s5_r;
    logic signed [34:0] term_s;
    logic [30:0]        q0;

    assign term_s = $signed({4'b0, it_term[n-1]});
    assign q0     = p_r[63:33];

    always_ff @(posedge clk) begin
      if (en) begin
        t1_r <= 32'((64'(it_term[n-1]) * 64'(it_x[n-1])) >> 30);
        x1_r <= it_x[n-1];
        // The previous term joins the sum here, with its alternating sign.
        if (((n - 1) % 2) == 1) begin
          s1_r <= it_sum[n-1] - term_s;
        end else begin
          s1_r <= it_sum[n-1] + term_s;
        end
        t2_r  <= 33'((64'(t1_r) * 64'(x1_r)) >> 30);
        x2_r  <= x1_r;
        s2_r  <= s1_r;
        p_r   <= 64'(t2_r) * 64'(RECIP);
        u3_r  <= t2_r;
        x3_r  <= x2_r;
        s3_r  <= s2_r;
        // The reciprocal estimate is at most one short; the remainder fixes it.
        q0_r  <= q0;
        rem_r <= 10'(34'(u3_r) - 34'(q0) * 34'(DIV));
        x4_r  <= x3_r;
        s4_r  <= s3_r;
        q_r   <= q0_r + 31'(rem_r >= 10'(DIV));
        x5_r  <= x4_r;
        s5_r  <= s4_r;
      end
    end

    assign it_x[n]    = x5_r;
    assign it_term[n] = q_r;
    assign it_sum[n]  = s5_r;
  end

  logic signed [34:0] sum_f;
  logic [SIN_W-1:0]   sin_r;

  assign sum_f = it_sum[SIN_TERMS] + $signed({4'b0, it_term[SIN_TERMS]});

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_f < 0) begin
        sin_r <= '0;
      end else if (sum_f > $signed({4'b0, ONE_Q30})) begin
        sin_r <= ONE_Q30;
      end else begin
        sin_r <= SIN_W'(sum_f);
      end
    end
  end

  assign sin_q = sin_r;

endmodule

// ----- design/planar_arm_tip_pose.sv -----
// Planar three-link arm forward kinematics, top level.
// Depends on pat_pkg, pat_in_if, pat_out_if and pat_sinq.
//
// Usage:
// The input channel carries three joint angles (1/64 degree) and the base
// position; the result channel returns the tip position, the heading of the
// last link and its unit direction, one result item per input item.
// Link length and body height are written through the cfg port while the
// block is idle; both reset to 2560 (10.0 in Q8.8).
// The Taylor sine pipelines (44 stages) plus angle reduction and the
// position multiply and saturate stages lie between acceptance and the
// result being shown. Throughput is one item per cycle while in_ch.ready
// is high: every stage advances together. A two-entry output register and
// skid stage let the pipeline keep advancing after the receiver stalls
// until a valid item fills the skid stage; then in_ch.ready drops until
// the skid stage drains. Nothing is lost or repeated under stalls.
// Reset is synchronous and clears all valid bits, output and skid stages included.
`timescale 1ns / 1ps

module planar_arm_tip_pose import pat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pat_in_if.sink           in_ch,
  pat_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned ST_SIN_IN  = 5;
  localparam int unsigned ST_SIN_OUT = ST_SIN_IN + SIN_LAT;
  localparam int unsigned ST_QUAD    = ST_SIN_OUT + 1;
  localparam int unsigned ST_SUM     = ST_QUAD + 1;
  localparam int unsigned ST_LAST    = ST_SUM + 3;

  typedef struct packed {
    coord_t          bx;
    coord_t          by;
    logic [2:0][1:0] qd;
    logic            hneg;
    head_t           heading;
    dir_t            dx;
    dir_t            dy;
  } side_t;

  typedef struct packed {
    coord_t tip_x;
    coord_t tip_y;
    head_t  heading;
    dir_t   dir_x;
    dir_t   dir_y;
  } res_t;

  // Configuration registers.
  logic [CFG_W-1:0] link_len_r, body_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_len_r <= LINK_LENGTH_RST;
      body_h_r   <= BODY_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_LINK_LENGTH: link_len_r <= cfg_data;
        REG_BODY_HEIGHT: body_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control.
  logic en, in_fire, skid_v_r, out_v_r;
  res_t out_d_r, skid_d_r, pipe_d;
  logic vld_r [1:ST_LAST];

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ST_LAST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_fire;
      for (int k = 2; k <= ST_LAST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Side data that rides along the pipeline.
  side_t side_r   [1:ST_LAST];
  side_t side_nxt [1:ST_LAST];

  // Angle reduction stages.
  logic signed [17:0] sum_a    [3];
  logic [17:0]        ap_r     [3];
  logic [17:0]        ap2_r    [3];
  logic [3:0]         q1_r     [3];
  logic [14:0]        m_r      [3];
  logic [14:0]        m4_r     [3];
  logic [1:0]         qd_c     [3];
  logic [ANG_RW-1:0]  r_nxt    [3];
  logic [ANG_RW-1:0]  r_r      [3];
  logic [ANG_RW-1:0]  rc_r     [3];
  logic [SIN_W-1:0]   sin_w    [3];
  logic [SIN_W-1:0]   cos_w    [3];

  assign sum_a[0] = 18'(in_ch.joint_one_angle);
  assign sum_a[1] = 18'(in_ch.joint_one_angle) + 18'(in_ch.joint_two_angle);
  assign sum_a[2] = 18'(in_ch.joint_one_angle) + 18'(in_ch.joint_two_angle)
                  + 18'(in_ch.joint_three_angle);

  for (genvar k = 0; k < 3; k++) begin : g_ang
    assign qd_c[k]  = 2'((19'(m_r[k][14:7]) * 19'(RCP45_S)) >> 16);
    assign r_nxt[k] = ANG_RW'(m4_r[k] - 15'(side_r[4].qd[k]) * 15'(QUARTER_TURN));

    always_ff @(posedge clk) begin
      if (en) begin
        // Offset by whole turns so the sum is never negative.
        ap_r[k]  <= 18'($unsigned(sum_a[k]) + 18'(TURN_OFFSET));
        ap2_r[k] <= ap_r[k];
        q1_r[k]  <= 4'((20'(ap_r[k][17:9]) * 20'(RCP45_S)) >> 16);
        m_r[k]   <= 15'(ap2_r[k] - 18'(q1_r[k]) * 18'(FULL_TURN));
        m4_r[k]  <= m_r[k];
        r_r[k]   <= r_nxt[k];
        rc_r[k]  <= ANG_RW'(14'(QUARTER_TURN) - 14'(r_nxt[k]));
      end
    end

    pat_sinq u_sin (.clk(clk), .en(en), .ang(r_r[k]),  .sin_q(sin_w[k]));
    pat_sinq u_cos (.clk(clk), .en(en), .ang(rc_r[k]), .sin_q(cos_w[k]));
  end

  // Heading: d = last link angle plus a quarter turn, in (-half, half].
  logic [15:0] d0, d1;
  logic [13:0] hmag_c, hmag_r;
  logic        hneg_c;
  logic [45:0] hp_r;
  logic [20:0] hv;
  logic [40:0] hprod_r;
  logic [14:0] hd_mag;

  always_comb begin
    d0 = 16'(m_r[2]) + 16'(QUARTER_TURN);
    d1 = (d0 >= 16'(FULL_TURN)) ? d0 - 16'(FULL_TURN) : d0;
    if (d1 > 16'(HALF_TURN)) begin
      hneg_c = 1'b1;
      hmag_c = 14'(16'(FULL_TURN) - d1);
    end else begin
      hneg_c = 1'b0;
      hmag_c = 14'(d1);
    end
  end

  // The divisor HALF_TURN << 17 is 45 << 25: round, shift by 25, then divide by 45.
  assign hv     = 21'((hp_r + 46'(45 * (64'd1 << 24))) >> 25);
  assign hd_mag = hprod_r[40:26];

  always_ff @(posedge clk) begin
    if (en) begin
      hmag_r  <= hmag_c;
      hp_r    <= 46'(hmag_r) * 46'(PI_Q30);
      hprod_r <= 41'(hv) * 41'(RCP45_L);
    end
  end

  // Quadrant fold, sums, direction and position.
  logic signed [31:0] s50_r [3];
  logic signed [31:0] c50_r [3];
  logic signed [33:0] sum_s_r, sum_c_r;
  logic signed [32:0] dx_t, dy_t;
  logic signed [50:0] ps_r, pc_r;
  logic signed [20:0] rs_r, rc2_r;
  logic signed [25:0] tx_f, ty_f;
  coord_t             tx_r, ty_r;

  for (genvar k = 0; k < 3; k++) begin : g_quad
    logic signed [31:0] sv, cv;
    assign sv = $signed({1'b0, sin_w[k]});
    assign cv = $signed({1'b0, cos_w[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        case (side_r[ST_SIN_OUT].qd[k])
          2'd0: begin
            s50_r[k] <= sv;
            c50_r[k] <= cv;
          end
          2'd1: begin
            s50_r[k] <= cv;
            c50_r[k] <= -sv;
          end
          2'd2: begin
            s50_r[k] <= -sv;
            c50_r[k] <= -cv;
          end
          default: begin
            s50_r[k] <= -cv;
            c50_r[k] <= sv;
          end
        endcase
      end
    end
  end

  assign dx_t = -33'(s50_r[2]) + 33'sd32768;
  assign dy_t = 33'(c50_r[2]) + 33'sd32768;

  assign tx_f = 26'(side_r[ST_LAST-1].bx) - 26'(rs_r);
  assign ty_f = 26'(side_r[ST_LAST-1].by) + 26'($signed({1'b0, body_h_r})) + 26'(rc2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s_r <= 34'(s50_r[0]) + 34'(s50_r[1]) + 34'(s50_r[2]);
      sum_c_r <= 34'(c50_r[0]) + 34'(c50_r[1]) + 34'(c50_r[2]);
      ps_r    <= 51'($signed({1'b0, link_len_r})) * 51'(sum_s_r);
      pc_r    <= 51'($signed({1'b0, link_len_r})) * 51'(sum_c_r);
      rs_r    <= 21'((ps_r + 51'sd536870912) >>> 30);
      rc2_r   <= 21'((pc_r + 51'sd536870912) >>> 30);
      if (tx_f > 26'sd8388607) begin
        tx_r <= 24'sd8388607;
      end else if (tx_f < -26'sd8388608) begin
        tx_r <= -24'sd8388608;
      end else begin
        tx_r <= 24'(tx_f);
      end
      if (ty_f > 26'sd8388607) begin
        ty_r <= 24'sd8388607;
      end else if (ty_f < -26'sd8388608) begin
        ty_r <= -24'sd8388608;
      end else begin
        ty_r <= 24'(ty_f);
      end
    end
  end

  always_comb begin
    side_nxt[1]    = '0;
    side_nxt[1].bx = in_ch.base_x;
    side_nxt[1].by = in_ch.base_y;
    for (int k = 2; k <= ST_LAST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    for (int k = 0; k < 3; k++) begin
      side_nxt[4].qd[k] = qd_c[k];
    end
    side_nxt[4].hneg    = hneg_c;
    side_nxt[7].heading = side_r[6].hneg ? -16'(hd_mag) : 16'(hd_mag);
    // A zero link length leaves the direction undefined; it reads as zero.
    if (link_len_r == '0) begin
      side_nxt[ST_SUM].dx = '0;
      side_nxt[ST_SUM].dy = '0;
    end else begin
      side_nxt[ST_SUM].dx = 16'(dx_t >>> 16);
      side_nxt[ST_SUM].dy = 16'(dy_t >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= ST_LAST; k++) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // Output register and skid stage.
  assign pipe_d.tip_x   = tx_r;
  assign pipe_d.tip_y   = ty_r;
  assign pipe_d.heading = side_r[ST_LAST].heading;
  assign pipe_d.dir_x   = side_r[ST_LAST].dx;
  assign pipe_d.dir_y   = side_r[ST_LAST].dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= vld_r[ST_LAST];
        out_d_r <= pipe_d;
      end
    end else if (vld_r[ST_LAST] && en) begin
      skid_v_r <= 1'b1;
      skid_d_r <= pipe_d;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.tip_x   = out_d_r.tip_x;
  assign out_ch.tip_y   = out_d_r.tip_y;
  assign out_ch.heading = out_d_r.heading;
  assign out_ch.dir_x   = out_d_r.dir_x;
  assign out_ch.dir_y   = out_d_r.dir_y;

endmodule

// ----- design/pat_checker.sv -----
// Port-level checker for the planar arm tip pose block, bound to the top level.
// Depends on pat_pkg for the register indexes, payload types and reset values.
`timescale 1ns / 1ps

module pat_checker import pat_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input coord_t           tip_x,
  input coord_t           tip_y,
  input head_t            heading,
  input dir_t             dir_x,
  input dir_t             dir_y,
  input logic             cfg_we,
  input logic [0:0]       cfg_idx,
  input logic [CFG_W-1:0] cfg_data
);

  // Shadow of the link length as written through the port.
  logic [CFG_W-1:0] link_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_len_r <= LINK_LENGTH_RST;
    end else if (cfg_we && cfg_idx == REG_LINK_LENGTH) begin
      link_len_r <= cfg_data;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({tip_x, tip_y, heading, dir_x, dir_y}))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item shown right after reset");

  a_zero_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && link_len_r == '0 |-> dir_x == '0 && dir_y == '0)
    else $error("direction not zero with zero link length");

  a_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> heading <= 16'sd25736 && heading >= -16'sd25736 &&
                  dir_x <= 16'sd16384 && dir_x >= -16'sd16384)
    else $error("heading or direction out of range");

endmodule

bind planar_arm_tip_pose pat_checker u_pat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .tip_x     (out_ch.tip_x),
  .tip_y     (out_ch.tip_y),
  .heading   (out_ch.heading),
  .dir_x     (out_ch.dir_x),
  .dir_y     (out_ch.dir_y),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_data  (cfg_data)
);

// ----- dv/planar_arm_tip_pose_test.sv -----
// Self-checking testbench for planar_arm_tip_pose: directed table, then random phases.
// Depends on pat_pkg, pat_in_if, pat_out_if and the planar_arm_tip_pose RTL.
`timescale 1ns / 1ps

module planar_arm_tip_pose_test;
  import pat_pkg::*;

  localparam int  LATENCY_WAIT = 80;
  localparam int  CYCLE_LIMIT  = 300000;
  localparam int  PHASE_ITEMS  = 140;
  localparam longint QTR  = longint'(QUARTER_TURN);
  localparam longint HALF = longint'(HALF_TURN);
  localparam longint FULL = longint'(FULL_TURN);

  typedef struct packed {
    angle_t j1;
    angle_t j2;
    angle_t j3;
    coord_t bx;
    coord_t by;
  } pose_t;

  typedef struct packed {
    coord_t tip_x;
    coord_t tip_y;
    head_t  heading;
    dir_t   dir_x;
    dir_t   dir_y;
  } tip_t;

  // A directed row; the has_* flags mark fields typed in by hand.
  typedef struct {
    pose_t  pose;
    bit     has_tx;
    coord_t tx;
    bit     has_ty;
    coord_t ty;
    bit     has_hd;
    head_t  hd;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  pat_in_if  in_ch ();
  pat_out_if out_ch ();

  planar_arm_tip_pose u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  logic [CFG_W-1:0] link_len;
  logic [CFG_W-1:0] mount_height;
  tip_t pending_tips[$];
  int   fail_count;
  int   items_sent;
  int   tips_seen;
  int   cycles;
  bit   calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Q30 sine of a first-quadrant angle in 1/64 degree, Taylor series to x^17.
  function automatic longint sine_q30(longint r);
    longint unsigned x, term;
    longint sum;
    x = (64'(r) * 64'(PI_Q30) + 64'd5760) / 64'd11520;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    return sum;
  endfunction

  function automatic void sin_cos(input longint a, output longint s, output longint c);
    longint m, q, r, sr, cr;
    m = ((a % FULL) + FULL) % FULL;
    q = m / QTR;
    r = m % QTR;
    sr = sine_q30(r);
    cr = sine_q30(QTR - r);
    case (q)
      0: begin s = sr; c = cr; end
      1: begin s = cr; c = -sr; end
      2: begin s = -sr; c = -cr; end
      default: begin s = -cr; c = sr; end
    endcase
  endfunction

  // Round half up, as a floor after adding half an LSB.
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic tip_t tip_of(pose_t p);
    longint a1, a2, a3, s1, c1, s2, c2, s3, c3, len, d;
    longint unsigned mag, den, hd;
    tip_t t;
    a1 = longint'(p.j1);
    a2 = a1 + longint'(p.j2);
    a3 = a2 + longint'(p.j3);
    sin_cos(a1, s1, c1);
    sin_cos(a2, s2, c2);
    sin_cos(a3, s3, c3);
    len = longint'(link_len);
    t.tip_x = coord_t'(clamp24(longint'(p.bx) - round_shift(len * (s1 + s2 + s3), 30)));
    t.tip_y = coord_t'(clamp24(longint'(p.by) + longint'(mount_height)
                               + round_shift(len * (c1 + c2 + c3), 30)));
    if (len == 0) begin
      t.dir_x = '0;
      t.dir_y = '0;
    end else begin
      t.dir_x = dir_t'(round_shift(-s3, 16));
      t.dir_y = dir_t'(round_shift(c3, 16));
    end
    d = (((a3 + QTR) % FULL) + FULL) % FULL;
    if (d > HALF) d -= FULL;
    mag = (d < 0) ? -d : d;
    den = 64'd11520 << 17;
    hd = (mag * 64'(PI_Q30) + den / 2) / den;
    t.heading = head_t'((d < 0) ? -longint'(hd) : longint'(hd));
    return t;
  endfunction

  always @(posedge clk) begin
    tip_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tips_seen++;
      if (pending_tips.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = pending_tips.pop_front();
        if (out_ch.tip_x !== want.tip_x) begin
          $error("tip_x expected %0d got %0d", want.tip_x, out_ch.tip_x);
          fail_count++;
        end
        if (out_ch.tip_y !== want.tip_y) begin
          $error("tip_y expected %0d got %0d", want.tip_y, out_ch.tip_y);
          fail_count++;
        end
        if (out_ch.heading !== want.heading) begin
          $error("heading expected %0d got %0d", want.heading, out_ch.heading);
          fail_count++;
        end
        if (out_ch.dir_x !== want.dir_x) begin
          $error("dir_x expected %0d got %0d", want.dir_x, out_ch.dir_x);
          fail_count++;
        end
        if (out_ch.dir_y !== want.dir_y) begin
          $error("dir_y expected %0d got %0d", want.dir_y, out_ch.dir_y);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls in random bursts, none once the run turns calm.
  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    if (idx == REG_LINK_LENGTH) link_len = value;
    else mount_height = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_tips.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // Offers one item and returns at the edge where it is taken, or after a random idle gap when the run is not calm.
  task automatic offer(pose_t p, tip_t want);
    in_ch.valid             <= 1'b1;
    in_ch.joint_one_angle   <= p.j1;
    in_ch.joint_two_angle   <= p.j2;
    in_ch.joint_three_angle <= p.j3;
    in_ch.base_x            <= p.bx;
    in_ch.base_y            <= p.by;
    do @(posedge clk); while (!in_ch.ready);
    pending_tips.push_back(want);
    items_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 3))
      0: return angle_t'($urandom_range(0, 8) * QUARTER_TURN);
      1: return angle_t'($urandom_range(0, 40) - 20);
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      2: return coord_t'($urandom_range(0, 4096) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  row_t rows[$];

  task automatic add_row(angle_t j1, angle_t j2, angle_t j3, coord_t bx, coord_t by,
                         bit htx, coord_t tx, bit hty, coord_t ty, bit hhd, head_t hd);
    row_t r;
    r.pose = '{j1: j1, j2: j2, j3: j3, bx: bx, by: by};
    r.has_tx = htx;
    r.tx = tx;
    r.has_ty = hty;
    r.ty = ty;
    r.has_hd = hhd;
    r.hd = hd;
    rows.push_back(r);
  endtask

  initial begin
    tip_t want;
    pose_t p;
    logic [CFG_W-1:0] lens[6], heights[6];
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_LINK_LENGTH;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.joint_one_angle   <= '0;
    in_ch.joint_two_angle   <= '0;
    in_ch.joint_three_angle <= '0;
    in_ch.base_x <= '0;
    in_ch.base_y <= '0;
    link_len     = LINK_LENGTH_RST;
    mount_height = BODY_HEIGHT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Straight up, quarter turns, the half turn heading, angle and base extremes.
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'sd12868);
    add_row(5760, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'sd25736);
    add_row(-5760, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'sd0);
    add_row(11520, 0, 0, 0, 0, 0, 0, 0, 0, 1, -16'sd12868);
    add_row(-17280, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'sd25736);
    add_row(-5760, 0, 0, 24'sh7fffff, 0, 1, 24'sh7fffff, 0, 0, 1, 16'sd0);
    add_row(11520, 0, 0, 0, -24'sh800000, 0, 0, 1, -24'sh800000, 1, -16'sd12868);
    add_row(5760, 0, 0, -24'sh800000, 0, 1, -24'sh800000, 0, 0, 1, 16'sd25736);
    add_row(0, 0, 0, 0, 24'sh7fffff, 0, 0, 1, 24'sh7fffff, 0, 0);
    add_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'sh7fff, -16'sh8000, 1, 24'sh123456, -24'sh123456, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 1, -1, -1, 0, 0, 0, 0, 0, 0);
    add_row(2880, 2880, 2880, 256, 256, 0, 0, 0, 0, 0, 0);
    add_row(1920, -3840, 7680, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(23040, -23040, 5759, 0, 0, 0, 0, 0, 0, 0, 0);

    foreach (rows[i]) begin
      want = tip_of(rows[i].pose);
      if (rows[i].has_tx) want.tip_x = rows[i].tx;
      if (rows[i].has_ty) want.tip_y = rows[i].ty;
      if (rows[i].has_hd) want.heading = rows[i].hd;
      offer(rows[i].pose, want);
    end
    in_ch.valid <= 1'b0;
    drain();

    lens    = '{16'd65535, 16'd0, 16'd1, 16'd0, 16'd0, LINK_LENGTH_RST};
    heights = '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, BODY_HEIGHT_RST};
    lens[3] = CFG_W'($urandom_range(1, 65535));
    heights[3] = CFG_W'($urandom);
    heights[2] = CFG_W'($urandom);
    lens[4] = CFG_W'($urandom_range(256, 4096));
    heights[4] = CFG_W'($urandom_range(0, 4096));
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LINK_LENGTH, lens[ph]);
      write_reg(REG_BODY_HEIGHT, heights[ph]);
      calm = (ph == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        p.j1 = rand_angle();
        p.j2 = rand_angle();
        p.j3 = rand_angle();
        p.bx = rand_coord();
        p.by = rand_coord();
        offer(p, tip_of(p));
        if (ph == 1 && k == PHASE_ITEMS / 2) begin
          // Hold the sender until the pipeline is empty.
          in_ch.valid <= 1'b0;
          while (pending_tips.size() != 0) @(posedge clk);
        end
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("Sent %0d pose items over seven register settings, %0d results checked.",
             items_sent, tips_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
